// ===== design/eelp_pkg.sv =====
// shared types and constants of the eit event loop parser
package eelp_pkg;

  // section layout
  localparam int unsigned TableHdrBytes = 6;
  localparam int unsigned EventHdrBytes = 12;
  localparam int unsigned HdrStoreDepth = EventHdrBytes - 1;
  localparam int unsigned HdrCntWidth   = $clog2(EventHdrBytes);
  localparam int unsigned LoopLenWidth  = 12;

  // front to back queue
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
  localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

  // header byte 10 bit positions
  localparam int unsigned FreeCaBit   = 4;
  localparam int unsigned LoopHiWidth = 4;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_HEADER,
    PH_TAG,
    PH_LEN,
    PH_DATA,
    PH_DISCARD
  } phase_e;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_DESC  = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic [15:0]             evt_ident;
    logic [39:0]             start_stamp;
    logic [23:0]             duration;
    logic [2:0]              run_state;
    logic                    free_ca;
    logic [LoopLenWidth-1:0] loop_length;
    logic [7:0]              desc_tag;
    logic [7:0]              desc_length;
    logic [7:0]              payload_byte;
    logic                    final_res;
  } result_t;

  // one classified input byte: an optional main result, then an optional section end
  typedef struct packed {
    logic    has_main;
    logic    has_end;
    result_t main;
  } entry_t;

endpackage

// ===== design/eelp_ifs.sv =====
// valid/ready channel interfaces for input bytes and parsed results
interface eelp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface eelp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] evt_ident;
  logic [39:0] start_stamp;
  logic [23:0] duration;
  logic [2:0]  run_state;
  logic        free_ca;
  logic [11:0] loop_length;
  logic [7:0]  desc_tag;
  logic [7:0]  desc_length;
  logic [7:0]  payload_byte;
  logic        final_res;

  modport source (output valid, output kind, output evt_ident, output start_stamp,
                  output duration, output run_state, output free_ca,
                  output loop_length, output desc_tag, output desc_length,
                  output payload_byte, output final_res, input ready);
  modport sink (input valid, input kind, input evt_ident, input start_stamp,
                input duration, input run_state, input free_ca,
                input loop_length, input desc_tag, input desc_length,
                input payload_byte, input final_res, output ready);
endinterface

// ===== design/eelp_front.sv =====
// front end: per-byte section parser that classifies each byte into a queue entry
module eelp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  first_byte_i,
  input  logic                  last_byte_i,
  input  logic                  push_ready_i,
  output logic                  push_valid_o,
  output eelp_pkg::entry_t      push_entry_o
);

  eelp_pkg::phase_e                        phase_q, phase_d;
  logic [2:0]                              skip_q, skip_d;
  logic [eelp_pkg::HdrCntWidth-1:0]        hcnt_q, hcnt_d;
  logic [eelp_pkg::LoopLenWidth-1:0]       loop_q, loop_d;
  logic [7:0]                              dleft_q, dleft_d;
  logic [7:0]                              tag_q, tag_d;
  logic [7:0]                              hdr_q [eelp_pkg::HdrStoreDepth];

  eelp_pkg::phase_e                        ph;
  logic [2:0]                              skip_c;
  logic [eelp_pkg::HdrCntWidth-1:0]        hcnt_c;
  logic [eelp_pkg::LoopLenWidth-1:0]       loop_c;
  logic [7:0]                              dleft_c;
  logic [2:0]                              skip_inc;
  logic [eelp_pkg::LoopLenWidth-1:0]       loop_new;
  logic [eelp_pkg::LoopLenWidth:0]         need;
  logic [7:0]                              dleft_dec;
  logic                                    hdr_wr;
  logic                                    accept;
  eelp_pkg::entry_t                        entry;

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && push_ready_i;
  assign push_valid_o = accept && (entry.has_main || entry.has_end);
  assign push_entry_o = entry;

  // first mark restarts the section parse
  always_comb begin
    ph      = first_byte_i ? eelp_pkg::PH_SKIP : phase_q;
    skip_c  = first_byte_i ? 3'd0 : skip_q;
    hcnt_c  = first_byte_i ? '0 : hcnt_q;
    loop_c  = first_byte_i ? '0 : loop_q;
    dleft_c = first_byte_i ? 8'd0 : dleft_q;
  end

  assign skip_inc  = skip_c + 3'd1;
  assign loop_new  = {hdr_q[eelp_pkg::HdrStoreDepth-1][eelp_pkg::LoopHiWidth-1:0], data_byte_i};
  assign need      = {{(eelp_pkg::LoopLenWidth-7){1'b0}}, data_byte_i} + 13'd2;
  assign dleft_dec = dleft_c - 8'd1;

  // next state and classification
  always_comb begin
    phase_d = ph;
    skip_d  = skip_c;
    hcnt_d  = hcnt_c;
    loop_d  = loop_c;
    dleft_d = dleft_c;
    tag_d   = tag_q;
    hdr_wr  = 1'b0;
    entry   = '0;

    case (ph)
      eelp_pkg::PH_SKIP: begin
        if (skip_inc >= 3'(eelp_pkg::TableHdrBytes)) begin
          skip_d  = 3'd0;
          hcnt_d  = '0;
          phase_d = eelp_pkg::PH_HEADER;
        end else begin
          skip_d = skip_inc;
        end
      end
      eelp_pkg::PH_HEADER: begin
        if (hcnt_c < eelp_pkg::HdrCntWidth'(eelp_pkg::HdrStoreDepth)) begin
          hdr_wr = 1'b1;
          hcnt_d = hcnt_c + 1'b1;
        end else begin
          entry.has_main          = 1'b1;
          entry.main.kind         = eelp_pkg::KIND_EVENT;
          entry.main.evt_ident    = {hdr_q[0], hdr_q[1]};
          entry.main.start_stamp  = {hdr_q[2], hdr_q[3], hdr_q[4], hdr_q[5], hdr_q[6]};
          entry.main.duration     = {hdr_q[7], hdr_q[8], hdr_q[9]};
          entry.main.run_state    = hdr_q[eelp_pkg::HdrStoreDepth-1][7:5];
          entry.main.free_ca      = hdr_q[eelp_pkg::HdrStoreDepth-1][eelp_pkg::FreeCaBit];
          entry.main.loop_length  = loop_new;
          loop_d  = loop_new;
          hcnt_d  = '0;
          phase_d = (loop_new < 12'd2) ? eelp_pkg::PH_HEADER : eelp_pkg::PH_TAG;
        end
      end
      eelp_pkg::PH_TAG: begin
        tag_d   = data_byte_i;
        phase_d = eelp_pkg::PH_LEN;
      end
      eelp_pkg::PH_LEN: begin
        if (need <= {1'b0, loop_c}) begin
          entry.has_main         = 1'b1;
          entry.main.kind        = eelp_pkg::KIND_DESC;
          entry.main.desc_tag    = tag_q;
          entry.main.desc_length = data_byte_i;
          loop_d = loop_c - need[eelp_pkg::LoopLenWidth-1:0];
          if (data_byte_i != 8'd0) begin
            dleft_d = data_byte_i;
            phase_d = eelp_pkg::PH_DATA;
          end else if (loop_d < 12'd2) begin
            hcnt_d  = '0;
            phase_d = eelp_pkg::PH_HEADER;
          end else begin
            phase_d = eelp_pkg::PH_TAG;
          end
        end else begin
          // descriptor overruns the loop: skip its data
          loop_d  = '0;
          dleft_d = data_byte_i;
          if (data_byte_i != 8'd0) begin
            phase_d = eelp_pkg::PH_DISCARD;
          end else begin
            hcnt_d  = '0;
            phase_d = eelp_pkg::PH_HEADER;
          end
        end
      end
      eelp_pkg::PH_DATA: begin
        entry.has_main          = 1'b1;
        entry.main.kind         = eelp_pkg::KIND_DATA;
        entry.main.payload_byte = data_byte_i;
        dleft_d = dleft_dec;
        if (dleft_dec == 8'd0) begin
          if (loop_c < 12'd2) begin
            hcnt_d  = '0;
            phase_d = eelp_pkg::PH_HEADER;
          end else begin
            phase_d = eelp_pkg::PH_TAG;
          end
        end
      end
      eelp_pkg::PH_DISCARD: begin
        dleft_d = dleft_dec;
        if (dleft_dec == 8'd0) begin
          hcnt_d  = '0;
          phase_d = eelp_pkg::PH_HEADER;
        end
      end
      default: begin
        skip_d  = 3'd0;
        phase_d = eelp_pkg::PH_SKIP;
      end
    endcase

    // section end follows any result of the last byte
    if (last_byte_i) begin
      entry.has_end = 1'b1;
      phase_d = eelp_pkg::PH_SKIP;
      skip_d  = 3'd0;
      hcnt_d  = '0;
      loop_d  = '0;
      dleft_d = 8'd0;
    end
    entry.main.final_res = entry.has_main && !entry.has_end;
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= eelp_pkg::PH_SKIP;
      skip_q  <= 3'd0;
      hcnt_q  <= '0;
      loop_q  <= '0;
      dleft_q <= 8'd0;
      tag_q   <= 8'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      hcnt_q  <= hcnt_d;
      loop_q  <= loop_d;
      dleft_q <= dleft_d;
      tag_q   <= tag_d;
    end
  end

  // event header byte store
  always_ff @(posedge clk_i) begin
    if (accept && hdr_wr) begin
      hdr_q[hcnt_c] <= data_byte_i;
    end
  end

endmodule

// ===== design/eelp_queue.sv =====
// short register queue between the parser and the result emitter
module eelp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  eelp_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output eelp_pkg::entry_t pop_entry_o
);

  eelp_pkg::entry_t                    mem_q [eelp_pkg::QueueDepth];
  logic [eelp_pkg::QueuePtrWidth-1:0]  wr_ptr_q, rd_ptr_q;
  logic [eelp_pkg::QueueCntWidth-1:0]  count_q;
  logic                                do_push, do_pop;

  assign push_ready_o = (count_q != eelp_pkg::QueueCntWidth'(eelp_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== design/eelp_back.sv =====
// back end: splits queue entries into results and holds them in the output register
module eelp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  input  eelp_pkg::entry_t  entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output eelp_pkg::result_t out_res_o
);

  logic              out_valid_q, out_valid_d;
  eelp_pkg::result_t out_q, out_d;
  logic              main_sent_q, main_sent_d;
  logic              load;

  assign load        = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // pick the next result of the head entry
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    main_sent_d = main_sent_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = pop_valid_i;
      if (pop_valid_i) begin
        if (entry_i.has_main && !main_sent_q) begin
          out_d = entry_i.main;
          if (entry_i.has_end) begin
            main_sent_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          out_d           = '0;
          out_d.kind      = eelp_pkg::KIND_END;
          out_d.final_res = 1'b1;
          main_sent_d     = 1'b0;
          pop_o           = 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      main_sent_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      main_sent_q <= main_sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== design/eit_event_loop_parser.sv =====
// top level of the eit event loop parser
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   in_i     | sink      | data_byte, first_byte, last_byte
//   out_o    | source    | kind, event fields, desc_tag/length, payload_byte,
//            |           | final_res
//
// one input byte is taken per cycle while the queue has room; a byte that yields a result
// plus the section end occupies the output for two transfers, the result then the end.
// a result passes from its byte's transfer through the queue and then the output
// register, which holds it until the result transfer happens.
// a four-entry queue decouples the parser from the output; input stalls only when it fills.
// reset clears parser state, queue pointers and the output valid; no clearing pass.
module eit_event_loop_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  eelp_in_if.sink    in_i,
  eelp_out_if.source out_o
);

  logic              push_valid, push_ready;
  eelp_pkg::entry_t  push_entry;
  logic              pop_valid, pop;
  eelp_pkg::entry_t  pop_entry;
  eelp_pkg::result_t res;

  // byte parser
  eelp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .data_byte_i  (in_i.data_byte),
    .first_byte_i (in_i.first_byte),
    .last_byte_i  (in_i.last_byte),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry)
  );

  // decoupling queue
  eelp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  // result emitter
  eelp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  assign out_o.kind         = res.kind;
  assign out_o.evt_ident    = res.evt_ident;
  assign out_o.start_stamp  = res.start_stamp;
  assign out_o.duration     = res.duration;
  assign out_o.run_state    = res.run_state;
  assign out_o.free_ca      = res.free_ca;
  assign out_o.loop_length  = res.loop_length;
  assign out_o.desc_tag     = res.desc_tag;
  assign out_o.desc_length  = res.desc_length;
  assign out_o.payload_byte = res.payload_byte;
  assign out_o.final_res    = res.final_res;

endmodule
